/* hdl/sida_pkg.sv */
// shared types and constants for the signed integer to decimal ascii block
package sida_pkg;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int BIT_CNT_W  = $clog2(VALUE_W);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_DIGITS
    } t_state;

    typedef struct packed {
        logic                    done;
        logic [BCD_W-1:0]        bcd;
    } t_dd_stat;

endpackage

/* hdl/signed_int_to_decimal_ascii.sv */
// top level: 32-bit value to decimal ascii characters, most significant first
//
//  channel   handshake          payload
//  in        start / busy       i_value[31:0], i_signed_mode
//  out       o_valid strobe     o_ascii_char[7:0], o_last_char
//
// an item is converted first in the bit-serial double-dabble shifter, one value bit
// per cycle, and then the digit positions are stepped through from the top, one per
// cycle, skipped leading zeros included.
// '-' appears the cycle after the item is taken; busy is high until the last
// character is out. reset is synchronous and clears the control state only.
// the receiver takes every character as it comes; nothing stalls the block.
module signed_int_to_decimal_ascii (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_value,
    input  logic        i_signed_mode,
    output logic        o_valid,
    output logic [7:0]  o_ascii_char,
    output logic        o_last_char
);

    localparam logic [sida_pkg::DIG_CNT_W-1:0] LAST_DIG =
        sida_pkg::DIG_CNT_W'(sida_pkg::NUM_DIGITS - 1);

    sida_pkg::t_state                r_state, n_state;
    logic [sida_pkg::BCD_W-1:0]      r_digits, n_digits;
    logic [sida_pkg::DIG_CNT_W-1:0]  r_dcnt, n_dcnt;
    logic                            r_lead, n_lead;
    logic                            r_valid, n_valid;
    logic [7:0]                      r_char, n_char;
    logic                            r_last, n_last;

    logic                            neg;
    logic [sida_pkg::VALUE_W-1:0]    mag;
    logic                            dd_start;
    sida_pkg::t_dd_stat              dd_stat;
    logic [3:0]                      top_dig;

    assign neg     = i_signed_mode & i_value[sida_pkg::VALUE_W-1];
    assign mag     = neg ? (~i_value + 1'b1) : i_value;
    assign top_dig = r_digits[sida_pkg::BCD_W-1 -: 4];

    sida_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dd_start),
        .i_value (mag),
        .o_stat  (dd_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sida_pkg::ST_IDLE;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            r_lead  <= 1'b0;
            r_dcnt  <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_last  <= n_last;
            r_lead  <= n_lead;
            r_dcnt  <= n_dcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digits <= n_digits;
        r_char   <= n_char;
    end

    always_comb begin
        n_state  = r_state;
        n_digits = r_digits;
        n_dcnt   = r_dcnt;
        n_lead   = r_lead;
        n_valid  = 1'b0;
        n_char   = r_char;
        n_last   = 1'b0;
        dd_start = 1'b0;
        case (r_state)
            sida_pkg::ST_IDLE: begin
                if (start) begin
                    dd_start = 1'b1;
                    n_state  = sida_pkg::ST_CONV;
                    if (neg) begin
                        n_valid = 1'b1;
                        n_char  = sida_pkg::CHAR_MINUS;
                    end
                end
            end
            sida_pkg::ST_CONV: begin
                if (dd_stat.done) begin
                    n_digits = dd_stat.bcd;
                    n_dcnt   = '0;
                    n_lead   = 1'b1;
                    n_state  = sida_pkg::ST_DIGITS;
                end
            end
            sida_pkg::ST_DIGITS: begin
                n_digits = {r_digits[sida_pkg::BCD_W-5:0], 4'b0000};
                n_dcnt   = r_dcnt + 1'b1;
                // leading zeros are dropped, but the units digit always goes out
                if (!(r_lead && top_dig == 4'd0 && r_dcnt != LAST_DIG)) begin
                    n_lead  = 1'b0;
                    n_valid = 1'b1;
                    n_char  = sida_pkg::CHAR_ZERO + {4'b0000, top_dig};
                    n_last  = (r_dcnt == LAST_DIG);
                    if (r_dcnt == LAST_DIG) begin
                        n_state = sida_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = sida_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy         = (r_state != sida_pkg::ST_IDLE);
    assign o_valid      = r_valid;
    assign o_ascii_char = r_char;
    assign o_last_char  = r_last;

endmodule

/* hdl/sida_dabble.sv */
// bit-serial binary to bcd converter, one value bit shifted in per cycle
module sida_dabble (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [sida_pkg::VALUE_W-1:0]  i_value,
    output sida_pkg::t_dd_stat            o_stat
);

    logic                            r_busy;
    logic [sida_pkg::BIT_CNT_W-1:0]  r_cnt;
    logic [sida_pkg::VALUE_W-1:0]    r_bin;
    logic [sida_pkg::BCD_W-1:0]      r_bcd;
    logic                            r_done;
    logic [sida_pkg::BCD_W-1:0]      adj;

    // add three to every digit of five or more before the shift
    always_comb begin
        logic [3:0] dig;
        adj = r_bcd;
        for (int d = 0; d < sida_pkg::NUM_DIGITS; d++) begin
            dig = r_bcd[4*d +: 4];
            if (dig >= 4'd5) begin
                adj[4*d +: 4] = dig + 4'd3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == sida_pkg::BIT_CNT_W'(sida_pkg::VALUE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (r_busy) begin
            r_bin <= {r_bin[sida_pkg::VALUE_W-2:0], 1'b0};
            r_bcd <= {adj[sida_pkg::BCD_W-2:0], r_bin[sida_pkg::VALUE_W-1]};
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.bcd  = r_bcd;

endmodule

/* hdl/sida_checker.sv */
// port-level checks on the decimal ascii formatter, bound to the top level
module sida_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic [7:0]  o_ascii_char,
    input logic        o_last_char
);

    // only a minus sign or a decimal digit is ever shown
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_ascii_char == sida_pkg::CHAR_MINUS) ||
                    (o_ascii_char >= sida_pkg::CHAR_ZERO &&
                     o_ascii_char <= sida_pkg::CHAR_ZERO + 8'd9))
        else $error("character outside sign and digit set");

    // the sign is never the final character
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ascii_char == sida_pkg::CHAR_MINUS) |-> !o_last_char)
        else $error("sign marked as last character");

    // conversion runs after the sign, so no character directly follows it
    a_sign_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_ascii_char == sida_pkg::CHAR_MINUS) |=> !o_valid)
        else $error("character right after sign");

    // an item in progress keeps the block busy
    a_busy_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last_char) |-> busy)
        else $error("block idle before last character");

    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("item taken but block not busy");

endmodule

bind signed_int_to_decimal_ascii sida_checker u_sida_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_ascii_char (o_ascii_char),
    .o_last_char  (o_last_char)
);
